/* sv/assert_macros.svh */
// Assertion macros for the checker file of the word token unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITEW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITEW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/itew_pkg.sv */
// Shared types, word codes and the microcode table of the word token unit.
// Used by the sequencer, the conversion datapath, the output stage and the top level.
package itew_pkg;

  localparam int unsigned WordW = 6;
  localparam int unsigned PcW   = 5;
  localparam int unsigned DigN  = 10;
  localparam int unsigned BcdW  = 4 * DigN;

  localparam logic [WordW-1:0] WORD_ZERO     = 6'd0;
  localparam logic [WordW-1:0] WORD_TEN      = 6'd10;
  localparam logic [WordW-1:0] WORD_TENS_OFS = 6'd18;
  localparam logic [WordW-1:0] WORD_HUNDRED  = 6'd28;
  localparam logic [WordW-1:0] WORD_THOUSAND = 6'd29;
  localparam logic [WordW-1:0] WORD_MILLION  = 6'd30;
  localparam logic [WordW-1:0] WORD_BILLION  = 6'd31;
  localparam logic [WordW-1:0] WORD_MINUS    = 6'd32;

  localparam logic [1:0] GRP_UNITS     = 2'd0;
  localparam logic [1:0] GRP_THOUSANDS = 2'd1;
  localparam logic [1:0] GRP_MILLIONS  = 2'd2;
  localparam logic [1:0] GRP_BILLIONS  = 2'd3;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DABBLE,
    OP_ZERO,
    OP_MINUS,
    OP_GROUP,
    OP_HUND_D,
    OP_HUND_W,
    OP_TEEN,
    OP_TENS,
    OP_UNIT,
    OP_SCALE,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [1:0]     grp;
    logic [PcW-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    logic [WordW-1:0] word;
    logic             plural;
  } emit_t;

  typedef struct packed {
    logic load;
    logic step;
  } bcd_ctrl_t;

  function automatic ucw_t mk(op_e op, logic [1:0] grp, logic [PcW-1:0] tgt);
    ucw_t w;
    w.op  = op;
    w.grp = grp;
    w.tgt = tgt;
    return w;
  endfunction

  // One control word per step. A zero group skips to the next group (units: to flush).
  function automatic ucw_t ucode(logic [PcW-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:    w = mk(OP_IDLE,   GRP_UNITS,     5'd0);
      5'd1:    w = mk(OP_DABBLE, GRP_UNITS,     5'd1);
      5'd2:    w = mk(OP_ZERO,   GRP_UNITS,     5'd31);
      5'd3:    w = mk(OP_MINUS,  GRP_UNITS,     5'd0);
      5'd4:    w = mk(OP_GROUP,  GRP_BILLIONS,  5'd11);
      5'd5:    w = mk(OP_HUND_D, GRP_BILLIONS,  5'd0);
      5'd6:    w = mk(OP_HUND_W, GRP_BILLIONS,  5'd0);
      5'd7:    w = mk(OP_TEEN,   GRP_BILLIONS,  5'd0);
      5'd8:    w = mk(OP_TENS,   GRP_BILLIONS,  5'd0);
      5'd9:    w = mk(OP_UNIT,   GRP_BILLIONS,  5'd0);
      5'd10:   w = mk(OP_SCALE,  GRP_BILLIONS,  5'd0);
      5'd11:   w = mk(OP_GROUP,  GRP_MILLIONS,  5'd18);
      5'd12:   w = mk(OP_HUND_D, GRP_MILLIONS,  5'd0);
      5'd13:   w = mk(OP_HUND_W, GRP_MILLIONS,  5'd0);
      5'd14:   w = mk(OP_TEEN,   GRP_MILLIONS,  5'd0);
      5'd15:   w = mk(OP_TENS,   GRP_MILLIONS,  5'd0);
      5'd16:   w = mk(OP_UNIT,   GRP_MILLIONS,  5'd0);
      5'd17:   w = mk(OP_SCALE,  GRP_MILLIONS,  5'd0);
      5'd18:   w = mk(OP_GROUP,  GRP_THOUSANDS, 5'd25);
      5'd19:   w = mk(OP_HUND_D, GRP_THOUSANDS, 5'd0);
      5'd20:   w = mk(OP_HUND_W, GRP_THOUSANDS, 5'd0);
      5'd21:   w = mk(OP_TEEN,   GRP_THOUSANDS, 5'd0);
      5'd22:   w = mk(OP_TENS,   GRP_THOUSANDS, 5'd0);
      5'd23:   w = mk(OP_UNIT,   GRP_THOUSANDS, 5'd0);
      5'd24:   w = mk(OP_SCALE,  GRP_THOUSANDS, 5'd0);
      5'd25:   w = mk(OP_GROUP,  GRP_UNITS,     5'd31);
      5'd26:   w = mk(OP_HUND_D, GRP_UNITS,     5'd0);
      5'd27:   w = mk(OP_HUND_W, GRP_UNITS,     5'd0);
      5'd28:   w = mk(OP_TEEN,   GRP_UNITS,     5'd0);
      5'd29:   w = mk(OP_TENS,   GRP_UNITS,     5'd0);
      5'd30:   w = mk(OP_UNIT,   GRP_UNITS,     5'd0);
      5'd31:   w = mk(OP_FLUSH,  GRP_UNITS,     5'd0);
      default: w = mk(OP_IDLE,   GRP_UNITS,     5'd0);
    endcase
    return w;
  endfunction

endpackage

/* sv/itew_bcd.sv */
// Binary to decimal conversion datapath: shift-and-add-three, two bits per cycle.
// Depends on itew_pkg for widths and the control struct.
module itew_bcd (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itew_pkg::bcd_ctrl_t               ctrl_i,
  input  logic signed [31:0]                value_i,
  output logic [itew_pkg::BcdW-1:0]         bcd_o,
  output logic                              neg_o,
  output logic                              last_step_o
);

  logic [31:0]               sh_q, sh_d, sh_nxt;
  logic [itew_pkg::BcdW-1:0] bcd_q, bcd_d, bcd_nxt;
  logic [3:0]                cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic [31:0]               mag;

  assign mag = value_i[31] ? (~value_i + 32'd1) : value_i;

  always_comb begin
    bcd_nxt = bcd_q;
    sh_nxt  = sh_q;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < itew_pkg::DigN; j++) begin
        if (bcd_nxt[j*4 +: 4] >= 4'd5) begin
          bcd_nxt[j*4 +: 4] = bcd_nxt[j*4 +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[itew_pkg::BcdW-2:0], sh_nxt[31]};
      sh_nxt  = {sh_nxt[30:0], 1'b0};
    end
  end

  always_comb begin
    sh_d  = sh_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (ctrl_i.load) begin
      sh_d  = mag;
      bcd_d = '0;
      cnt_d = '0;
      neg_d = value_i[31];
    end else if (ctrl_i.step) begin
      sh_d  = sh_nxt;
      bcd_d = bcd_nxt;
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign bcd_o       = bcd_q;
  assign neg_o       = neg_q;
  assign last_step_o = (cnt_q == 4'd15);

endmodule

/* sv/itew_seq.sv */
// Microcoded sequencer: step counter, control word decode and word selection.
// Depends on itew_pkg for the microcode table, opcodes and word codes.
module itew_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [itew_pkg::BcdW-1:0]   bcd_i,
  input  logic                        neg_i,
  input  logic                        last_step_i,
  output itew_pkg::bcd_ctrl_t         bcd_ctrl_o,
  output itew_pkg::emit_t             emit_o,
  input  logic                        busy_i
);

  logic [itew_pkg::PcW-1:0] pc_q, pc_d, pc_inc;
  itew_pkg::ucw_t           cw;
  logic [47:0]              dig;
  logic [3:0]               base;
  logic [3:0]               h, d, u;
  logic                     grp_zero, grp_one, stall;
  itew_pkg::emit_t          em;

  assign cw     = itew_pkg::ucode(pc_q);
  assign pc_inc = pc_q + 5'd1;
  assign dig    = {8'd0, bcd_i};
  assign base   = {2'b00, cw.grp} + {1'b0, cw.grp, 1'b0};
  assign u      = dig[{base, 2'b00} +: 4];
  assign d      = dig[{base + 4'd1, 2'b00} +: 4];
  assign h      = dig[{base + 4'd2, 2'b00} +: 4];
  assign grp_zero = (h == 4'd0) && (d == 4'd0) && (u == 4'd0);
  assign grp_one  = (h == 4'd0) && (d == 4'd0) && (u == 4'd1);

  always_comb begin
    em        = '0;
    case (cw.op)
      itew_pkg::OP_ZERO: begin
        em.push = (bcd_i == '0);
        em.word = itew_pkg::WORD_ZERO;
      end
      itew_pkg::OP_MINUS: begin
        em.push = neg_i;
        em.word = itew_pkg::WORD_MINUS;
      end
      itew_pkg::OP_HUND_D: begin
        em.push = (h != 4'd0);
        em.word = {2'b00, h};
      end
      itew_pkg::OP_HUND_W: begin
        em.push = (h != 4'd0);
        em.word = itew_pkg::WORD_HUNDRED;
      end
      itew_pkg::OP_TEEN: begin
        em.push = (d == 4'd1);
        em.word = itew_pkg::WORD_TEN + {2'b00, u};
      end
      itew_pkg::OP_TENS: begin
        em.push = (d > 4'd1);
        em.word = itew_pkg::WORD_TENS_OFS + {2'b00, d};
      end
      itew_pkg::OP_UNIT: begin
        em.push = (d != 4'd1) && (u != 4'd0);
        em.word = {2'b00, u};
      end
      itew_pkg::OP_SCALE: begin
        em.push = 1'b1;
        case (cw.grp)
          itew_pkg::GRP_BILLIONS: em.word = itew_pkg::WORD_BILLION;
          itew_pkg::GRP_MILLIONS: em.word = itew_pkg::WORD_MILLION;
          default:                em.word = itew_pkg::WORD_THOUSAND;
        endcase
        em.plural = (cw.grp != itew_pkg::GRP_THOUSANDS) && !grp_one;
      end
      itew_pkg::OP_FLUSH: begin
        em.flush = 1'b1;
      end
      default: begin
        em = '0;
      end
    endcase
  end

  assign stall = (em.push || em.flush) && busy_i;

  always_comb begin
    pc_d = pc_inc;
    case (cw.op)
      itew_pkg::OP_IDLE:   pc_d = in_valid_i ? pc_inc : pc_q;
      itew_pkg::OP_DABBLE: pc_d = last_step_i ? pc_inc : cw.tgt;
      itew_pkg::OP_ZERO:   pc_d = (bcd_i == '0) ? cw.tgt : pc_inc;
      itew_pkg::OP_GROUP:  pc_d = grp_zero ? cw.tgt : pc_inc;
      itew_pkg::OP_FLUSH:  pc_d = cw.tgt;
      default:             pc_d = pc_inc;
    endcase
    if (stall) begin
      pc_d = pc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o      = (cw.op == itew_pkg::OP_IDLE);
  assign bcd_ctrl_o.load = in_ready_o && in_valid_i;
  assign bcd_ctrl_o.step = (cw.op == itew_pkg::OP_DABBLE);
  assign emit_o.push     = em.push && !busy_i;
  assign emit_o.flush    = em.flush && !busy_i;
  assign emit_o.word     = em.word;
  assign emit_o.plural   = em.plural;

endmodule

/* sv/itew_outq.sv */
// Output stage: one held word that waits to learn whether it is last, then the output register.
// Depends on itew_pkg for the emit struct and word width.
module itew_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itew_pkg::emit_t               emit_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [itew_pkg::WordW-1:0]    out_word_o,
  output logic                          out_plural_o,
  output logic                          out_last_o
);

  logic                       held_vld_q, held_vld_d;
  logic [itew_pkg::WordW-1:0] held_word_q, held_word_d;
  logic                       held_plural_q, held_plural_d;
  logic                       out_vld_q, out_vld_d;
  logic [itew_pkg::WordW-1:0] out_word_q, out_word_d;
  logic                       out_plural_q, out_plural_d;
  logic                       out_last_q, out_last_d;
  logic                       move;

  assign busy_o = held_vld_q && out_vld_q && !out_ready_i;
  assign move   = (emit_i.push && held_vld_q) || emit_i.flush;

  always_comb begin
    held_vld_d    = held_vld_q;
    held_word_d   = held_word_q;
    held_plural_d = held_plural_q;
    out_vld_d     = out_vld_q && !out_ready_i;
    out_word_d    = out_word_q;
    out_plural_d  = out_plural_q;
    out_last_d    = out_last_q;
    if (move) begin
      out_vld_d    = 1'b1;
      out_word_d   = held_word_q;
      out_plural_d = held_plural_q;
      out_last_d   = emit_i.flush;
    end
    if (emit_i.push) begin
      held_vld_d    = 1'b1;
      held_word_d   = emit_i.word;
      held_plural_d = emit_i.plural;
    end else if (emit_i.flush) begin
      held_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      held_vld_q <= held_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_word_q   <= held_word_d;
    held_plural_q <= held_plural_d;
    out_word_q    <= out_word_d;
    out_plural_q  <= out_plural_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_word_o   = out_word_q;
  assign out_plural_o = out_plural_q;
  assign out_last_o   = out_last_q;

endmodule

/* sv/integer_to_english_word_tokens_unit.sv */
// Top level of the integer to English word token unit.
// Instantiates itew_bcd, itew_seq and itew_outq; depends on itew_pkg.
//
//   channel   dir  tdata bits                 tuser     tlast
//   s_axis    in   [31:0] value (signed)      -         -
//   m_axis    out  [5:0] word, [7:6] zero     plural    last_word
//
// A number is accepted, converted by shift-and-add-three two bits at a time, then
// walked through the microcode one step per cycle while the output does not stall,
// with a zero group skipping its remaining steps.
// Reset clears the step counter and the output valid flags; the unit then idles.
// A stalled output stops the step counter on the next word it must emit.
module integer_to_english_word_tokens_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] word, [7:6] zero
  output logic        m_axis_tuser_o,   // [0] plural
  output logic        m_axis_tlast_o
);

  itew_pkg::bcd_ctrl_t          bcd_ctrl;
  itew_pkg::emit_t              emit;
  logic [itew_pkg::BcdW-1:0]    bcd;
  logic                         neg, last_step, busy;
  logic [itew_pkg::WordW-1:0]   word;

  itew_bcd u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (bcd_ctrl),
    .value_i     (s_axis_tdata_i),
    .bcd_o       (bcd),
    .neg_o       (neg),
    .last_step_o (last_step)
  );

  itew_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .bcd_i       (bcd),
    .neg_i       (neg),
    .last_step_i (last_step),
    .bcd_ctrl_o  (bcd_ctrl),
    .emit_o      (emit),
    .busy_i      (busy)
  );

  itew_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_word_o   (word),
    .out_plural_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, word};

endmodule

/* sv/itew_chk.sv */
// Port-level checker for the word token unit, bound to the top level.
// Depends on assert_macros.svh and itew_pkg for the word codes.
`include "assert_macros.svh"

module itew_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `ITEW_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o), "output changed while stalled")
  `ITEW_ASSERT_IMP(a_word_range, m_axis_tvalid_o,
                   m_axis_tdata_o[7:6] == 2'b00 && m_axis_tdata_o[5:0] <= itew_pkg::WORD_MINUS,
                   "word code out of range")
  `ITEW_ASSERT_IMP(a_plural_scale, m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o[5:0] == itew_pkg::WORD_MILLION ||
                   m_axis_tdata_o[5:0] == itew_pkg::WORD_BILLION,
                   "plural on a word other than Million or Billion")
  `ITEW_ASSERT_IMP(a_last_not_minus, m_axis_tvalid_o && m_axis_tlast_o,
                   m_axis_tdata_o[5:0] != itew_pkg::WORD_MINUS, "number ends on Minus")
  `ITEW_ASSERT_NXT(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o,
                   "input taken again right after a transfer")

endmodule

bind integer_to_english_word_tokens_unit itew_chk u_itew_chk (.*);
